### src/bgre_pkg.sv
`default_nettype none

package bgre_pkg;

    localparam int GLYPH_COUNT = 95;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam logic [7:0] SUBST_CODE = 8'd63;   // '?'

    localparam logic [3:0] MAX_PIXELS    = 4'd8;
    localparam logic [3:0] NARROW_WIDTH  = 4'd6;  // width that starts at bit 6

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GLYPH_WIDTH  = 3'd0,
        CFG_GLYPH_HEIGHT = 3'd1,
        CFG_FG_COLOR     = 3'd2,
        CFG_BG_COLOR     = 3'd3,
        CFG_TRANSPARENT  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
    localparam logic [4:0]  RST_GLYPH_HEIGHT = 5'd16;
    localparam logic [15:0] RST_FG_COLOR     = 16'hFFFF;
    localparam logic [15:0] RST_BG_COLOR     = 16'h0000;

endpackage

`default_nettype wire

### src/bitmap_glyph_row_expander_core.sv
`default_nettype none

// Channel   Ports                                          Direction
// --------  ---------------------------------------------  ---------
// input     s_valid s_ready s_cmd s_char_code s_glyph_row  in
//           s_font_bits
// result    m_valid m_ready m_pixel m_last                 out
// config    cfg_we cfg_index cfg_wdata                     in
//
// A render transfer yields glyph_width pixels (saturated at 8, none for 0), one per
// cycle unless m_ready stalls the emitter; the emitter's column counter sets the
// rate, and the next render waits in the read stage. Loads and empty renders yield
// nothing. The first pixel passes the read stage, the emitter and the output reg.
// Reset is synchronous; the glyph store is not cleared.
// Backpressure on m_ready stalls the emitter, then the read stage, then s_ready.

module bitmap_glyph_row_expander_core #(
    parameter int MAX_GLYPH_ROWS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_cmd,
    input  wire logic [7:0]                        s_char_code,
    input  wire logic [3:0]                        s_glyph_row,
    input  wire logic [7:0]                        s_font_bits,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [15:0]                            m_pixel,
    output logic                                   m_last,

    input  wire logic                              cfg_we,
    input  wire logic [bgre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bgre_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int STORE_DEPTH = bgre_pkg::GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int AW          = $clog2(STORE_DEPTH);

    // configuration
    logic [3:0]  cfg_width_reg;
    logic [4:0]  cfg_height_reg;
    logic [15:0] cfg_fg_reg;
    logic [15:0] cfg_bg_reg;
    logic        cfg_transp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= bgre_pkg::RST_GLYPH_WIDTH;
            cfg_height_reg <= bgre_pkg::RST_GLYPH_HEIGHT;
            cfg_fg_reg     <= bgre_pkg::RST_FG_COLOR;
            cfg_bg_reg     <= bgre_pkg::RST_BG_COLOR;
            cfg_transp_reg <= 1'b0;
        end else if (cfg_we) begin
            case (bgre_pkg::cfg_index_t'(cfg_index))
                bgre_pkg::CFG_GLYPH_WIDTH:  cfg_width_reg  <= cfg_wdata[3:0];
                bgre_pkg::CFG_GLYPH_HEIGHT: cfg_height_reg <= cfg_wdata[4:0];
                bgre_pkg::CFG_FG_COLOR:     cfg_fg_reg     <= cfg_wdata;
                bgre_pkg::CFG_BG_COLOR:     cfg_bg_reg     <= cfg_wdata;
                bgre_pkg::CFG_TRANSPARENT:  cfg_transp_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input decode
    logic          s_fire;
    logic          code_ok;
    logic          row_in_store;
    logic [7:0]    eff_code;
    logic [6:0]    glyph_idx;
    logic [AW-1:0] store_addr;
    logic [3:0]    eff_width;
    logic          wr_en;
    logic          rd_en;

    assign s_fire       = s_valid && s_ready;
    assign code_ok      = (s_char_code >= bgre_pkg::FIRST_CODE) &&
                          (s_char_code <= bgre_pkg::LAST_CODE);
    assign row_in_store = 32'(s_glyph_row) < MAX_GLYPH_ROWS;
    assign eff_code     = code_ok ? s_char_code : bgre_pkg::SUBST_CODE;
    assign glyph_idx    = 7'(eff_code - bgre_pkg::FIRST_CODE);
    assign store_addr   = AW'(glyph_idx) * AW'(MAX_GLYPH_ROWS) + AW'(s_glyph_row);
    assign eff_width    = (cfg_width_reg > bgre_pkg::MAX_PIXELS) ?
                          bgre_pkg::MAX_PIXELS : cfg_width_reg;

    assign wr_en = s_fire && (s_cmd == bgre_pkg::CMD_LOAD) && code_ok && row_in_store;
    assign rd_en = s_fire && (s_cmd == bgre_pkg::CMD_RENDER) && row_in_store &&
                   ({1'b0, s_glyph_row} < cfg_height_reg) && (eff_width != 4'd0);

    // glyph store: single port; a load and a render never share a cycle,
    // so a render right after a load reads the new byte.
    logic [7:0] glyph_mem [STORE_DEPTH];
    logic [7:0] mem_q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            glyph_mem[store_addr] <= s_font_bits;
        end
        if (rd_en) begin
            mem_q_reg <= glyph_mem[store_addr];
        end
    end

    // read stage
    logic       rd_valid_reg;
    logic       rd_valid_next;
    logic [3:0] rd_width_reg;

    // emitter
    logic       em_valid_reg;
    logic [7:0] em_data_reg;
    logic [2:0] em_col_reg;
    logic [3:0] em_width_reg;
    logic       out_free;
    logic       emit_fire;
    logic       em_last;
    logic       em_done;
    logic       em_load;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_pixel_reg;
    logic        m_last_reg;
    logic [15:0] pixel_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = em_valid_reg && out_free;
    assign em_last   = ({1'b0, em_col_reg} + 4'd1) == em_width_reg;
    assign em_done   = emit_fire && em_last;
    assign em_load   = rd_valid_reg && (!em_valid_reg || em_done);
    assign s_ready   = !rd_valid_reg || em_load;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (rd_en) begin
            rd_valid_next = 1'b1;
        end else if (em_load) begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_width_reg <= eff_width;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
        end else if (em_load) begin
            em_valid_reg <= 1'b1;
        end else if (em_done) begin
            em_valid_reg <= 1'b0;
        end
    end

    // width 6 starts at bit 6: pre-shift so the emitter always takes bit 7
    always_ff @(posedge aclk) begin
        if (em_load) begin
            em_data_reg  <= (rd_width_reg == bgre_pkg::NARROW_WIDTH) ?
                            {mem_q_reg[6:0], 1'b0} : mem_q_reg;
            em_col_reg   <= 3'd0;
            em_width_reg <= rd_width_reg;
        end else if (emit_fire) begin
            em_data_reg <= {em_data_reg[6:0], 1'b0};
            em_col_reg  <= em_col_reg + 3'd1;
        end
    end

    always_comb begin
        if (em_data_reg[7]) begin
            pixel_next = cfg_fg_reg;
        end else if (cfg_transp_reg) begin
            pixel_next = 16'h0000;
        end else begin
            pixel_next = cfg_bg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_pixel_reg <= pixel_next;
            m_last_reg  <= em_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pixel = m_pixel_reg;
    assign m_last  = m_last_reg;

    // checks
    a_render_reaches_read_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> rd_valid_reg)
        else $error("accepted render did not enter the read stage");

    a_emitter_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        em_valid_reg |-> (({1'b0, em_col_reg} < em_width_reg) && (em_width_reg != 4'd0)))
        else $error("emitter column outside glyph width");

    a_read_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && !em_load) |=> $stable(mem_q_reg))
        else $error("glyph read data changed while the read stage stalled");

    a_last_follows_final_col: assert property (@(posedge aclk) disable iff (!aresetn)
        em_done |=> (m_valid_reg && m_last_reg))
        else $error("final column did not produce a last pixel");

endmodule

`default_nettype wire

### tb/sv/bitmap_glyph_row_expander_core_tb.sv
`default_nettype none

module bitmap_glyph_row_expander_core_tb;

    localparam int GLYPH_ROWS   = 16;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;

    localparam logic [7:0] BIT6_MASK = 8'h40;
    localparam logic [7:0] BIT7_MASK = 8'h80;

    typedef struct packed {
        bgre_pkg::cmd_t cmd;
        logic [7:0]     code;
        logic [3:0]     row;
        logic [7:0]     bits;
    } glyph_req_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
    } pixel_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_cmd       = 1'b0;
    logic [7:0]  s_char_code = 8'd0;
    logic [3:0]  s_glyph_row = 4'd0;
    logic [7:0]  s_font_bits = 8'd0;

    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_pixel;
    logic        m_last;

    logic                             cfg_we    = 1'b0;
    logic [bgre_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bgre_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    bitmap_glyph_row_expander_core #(
        .MAX_GLYPH_ROWS(GLYPH_ROWS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_char_code(s_char_code),
        .s_glyph_row(s_glyph_row),
        .s_font_bits(s_font_bits),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pixel    (m_pixel),
        .m_last     (m_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // shadow of the block's registers and glyph store
    logic [3:0]  width_cfg  = bgre_pkg::RST_GLYPH_WIDTH;
    logic [4:0]  height_cfg = bgre_pkg::RST_GLYPH_HEIGHT;
    logic [15:0] fg_cfg     = bgre_pkg::RST_FG_COLOR;
    logic [15:0] bg_cfg     = bgre_pkg::RST_BG_COLOR;
    logic        transp_cfg = 1'b0;
    logic [7:0]  glyph_rows [bgre_pkg::GLYPH_COUNT][GLYPH_ROWS];

    // rows the stimulus has already queued a load for
    bit          rows_planned [bgre_pkg::GLYPH_COUNT][GLYPH_ROWS];

    glyph_req_t  pending_reqs[$];
    pixel_beat_t expected_pixels[$];
    glyph_req_t  next_req;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    bit timed_out     = 1'b0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic bit is_printable(logic [7:0] code);
        return code >= bgre_pkg::FIRST_CODE && code <= bgre_pkg::LAST_CODE;
    endfunction

    function automatic logic [7:0] pick_bits();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_load(logic [7:0] code, logic [3:0] row, logic [7:0] bits);
        glyph_req_t req;
        req.cmd  = bgre_pkg::CMD_LOAD;
        req.code = code;
        req.row  = row;
        req.bits = bits;
        pending_reqs.push_back(req);
        if (is_printable(code))
            rows_planned[code - bgre_pkg::FIRST_CODE][row] = 1'b1;
    endfunction

    // a render never reads a store row that has not been loaded
    function automatic void queue_render(logic [7:0] code, logic [3:0] row);
        glyph_req_t req;
        logic [7:0] eff;
        eff = is_printable(code) ? code : bgre_pkg::SUBST_CODE;
        if (!rows_planned[eff - bgre_pkg::FIRST_CODE][row])
            queue_load(eff, row, pick_bits());
        req.cmd  = bgre_pkg::CMD_RENDER;
        req.code = code;
        req.row  = row;
        req.bits = 8'($urandom_range(255));
        pending_reqs.push_back(req);
    endfunction

    function automatic void expand_glyph_row(logic [7:0] code, logic [3:0] row);
        logic [7:0]  eff;
        logic [7:0]  data;
        logic [7:0]  mask;
        int          npix;
        pixel_beat_t beat;
        if (row >= height_cfg)
            return;
        eff  = is_printable(code) ? code : bgre_pkg::SUBST_CODE;
        data = glyph_rows[eff - bgre_pkg::FIRST_CODE][row];
        npix = (width_cfg > bgre_pkg::MAX_PIXELS) ? int'(bgre_pkg::MAX_PIXELS)
                                                  : int'(width_cfg);
        mask = (npix == int'(bgre_pkg::NARROW_WIDTH)) ? BIT6_MASK : BIT7_MASK;
        for (int col = 0; col < npix; col++) begin
            if ((data & (mask >> col)) != 8'd0)
                beat.pixel = fg_cfg;
            else
                beat.pixel = transp_cfg ? 16'h0000 : bg_cfg;
            beat.last = (col == npix - 1);
            expected_pixels.push_back(beat);
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                s_valid     <= 1'b1;
                s_cmd       <= next_req.cmd;
                s_char_code <= next_req.code;
                s_glyph_row <= next_req.row;
                s_font_bits <= next_req.bits;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        pixel_beat_t beat;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_cmd == bgre_pkg::CMD_LOAD) begin
                    if (is_printable(s_char_code))
                        glyph_rows[s_char_code - bgre_pkg::FIRST_CODE][s_glyph_row] =
                            s_font_bits;
                end else begin
                    expand_glyph_row(s_char_code, s_glyph_row);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel: unexpected transfer, got %h last %b", m_pixel, m_last);
                    mismatches++;
                end else begin
                    beat = expected_pixels.pop_front();
                    if (m_pixel !== beat.pixel) begin
                        $error("pixel: expected %h, got %h", beat.pixel, m_pixel);
                        mismatches++;
                    end
                    if (m_last !== beat.last) begin
                        $error("last: expected %b, got %b", beat.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
            timed_out <= 1'b1;
    end

    task automatic wait_for_drain();
        while (pending_reqs.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(bgre_pkg::cfg_index_t idx, logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic program_glyph_format(int w, int h, int fg, int bg, int tr);
        write_reg(bgre_pkg::CFG_GLYPH_WIDTH, 16'(w));
        write_reg(bgre_pkg::CFG_GLYPH_HEIGHT, 16'(h));
        write_reg(bgre_pkg::CFG_FG_COLOR, 16'(fg));
        write_reg(bgre_pkg::CFG_BG_COLOR, 16'(bg));
        write_reg(bgre_pkg::CFG_TRANSPARENT, 16'(tr));
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_cfg  = 4'(w);
        height_cfg = 5'(h);
        fg_cfg     = 16'(fg);
        bg_cfg     = 16'(bg);
        transp_cfg = 1'(tr);
    endtask

    task automatic run_phase(int w, int h, int fg, int bg, int tr,
                             int send_pct, int rx_pct, int count);
        logic [7:0] code;
        logic [3:0] row;
        int         rows_live;
        wait_for_drain();
        program_glyph_format(w, h, fg, bg, tr);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        rows_live = (h > GLYPH_ROWS) ? GLYPH_ROWS : h;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 35) begin
                code = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(126, 32));
                queue_load(code, 4'($urandom_range(15)), pick_bits());
            end else begin
                code = ($urandom_range(6) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(126, 32));
                // mostly rows inside the glyph height, some past it
                if ($urandom_range(3) == 0 || rows_live == 0)
                    row = 4'($urandom_range(15));
                else
                    row = 4'($urandom_range(rows_live - 1));
                queue_render(code, row);
            end
        end
    endtask

    initial begin
        fork
            begin
                repeat (RESET_CYCLES) @(posedge aclk);
                aresetn <= 1'b1;

                // directed, at reset settings
                queue_load(bgre_pkg::SUBST_CODE, 4'd0, 8'hA5);
                queue_load(bgre_pkg::FIRST_CODE, 4'd0, 8'hFF);
                queue_load(bgre_pkg::LAST_CODE, 4'd15, 8'h01);
                queue_load(8'd31, 4'd0, 8'hFF);      // out of range loads are dropped
                queue_load(8'd127, 4'd0, 8'hFF);
                queue_load(8'd0, 4'd0, 8'hFF);
                queue_load(8'd255, 4'd15, 8'hFF);
                queue_load(8'd65, 4'd7, 8'h80);
                queue_load(8'd33, 4'd1, 8'h00);
                queue_render(bgre_pkg::FIRST_CODE, 4'd0);
                queue_render(bgre_pkg::LAST_CODE, 4'd15);
                queue_render(8'd0, 4'd0);            // non-printable renders show '?'
                queue_render(8'd255, 4'd0);
                queue_render(8'd31, 4'd0);
                queue_render(8'd127, 4'd0);
                queue_render(8'd65, 4'd7);
                queue_render(8'd33, 4'd1);
                queue_load(bgre_pkg::SUBST_CODE, 4'd0, 8'h5A);
                queue_render(bgre_pkg::SUBST_CODE, 4'd0);
                queue_render(8'd200, 4'd0);

                run_phase(1, 1, 16'h0000, 16'hFFFF, 0, 79, 0, 13);
                run_phase(6, 16, 16'h1234, 16'hABCD, 1, 0, 79, 13);
                run_phase(8, 16, 16'hFFFF, 16'h0000, 0, 29, 29, 13);
                run_phase(0, 9, 16'hF800, 16'h07E0, 0, 0, 0, 10);
                run_phase(15, 20, 16'h5555, 16'hAAAA, 1, 79, 0, 13);
                run_phase(3, 3, $urandom_range(65535), $urandom_range(65535), 0, 0, 79, 13);
                run_phase(6, 9, $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(1), 29, 29, 13);
                run_phase(8, 16, $urandom_range(65535), $urandom_range(65535), 0, 0, 0, 12);
                wait_for_drain();
            end
            begin
                wait (timed_out);
                $error("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            end
        join_any
        if (!timed_out && mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
